@@ rtl/dtlh_pkg.sv @@
// Shared types, limits and status codes of the DER tag/length header parser.
package dtlh_pkg;

   localparam int MAX_TAG_GROUPS   = 4;
   localparam int MAX_LENGTH_BYTES = 4;

   localparam int TAG_GROUPS_W = $clog2(MAX_TAG_GROUPS + 1);
   localparam int LEN_LEFT_W   = $clog2(MAX_LENGTH_BYTES + 1);

   localparam logic [7:0] TAG_LOW_MASK  = 8'h1f;
   localparam logic [7:0] GROUP_MASK    = 8'h7f;
   localparam logic [7:0] LONG_FORM_BIT = 8'h80;
   localparam logic [7:0] CLASS_MASK    = 8'hc0;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_TRUNC  = 3'd1,
      ST_EOC    = 3'd2,
      ST_INDEF  = 3'd3,
      ST_TAGBIG = 3'd4,
      ST_LENBIG = 3'd5
   } status_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  tag_class;
      logic [27:0] tag_number;
      logic [31:0] content_length;
      logic [3:0]  header_bytes;
   } rsp_word_type;

endpackage

@@ rtl/dtlh_rsp_queue.sv @@
// Two-entry output register with skid stage for parser result words.
module dtlh_rsp_queue
   import dtlh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_word_type push_word,
   output logic         full,
   output logic         rsp_valid,
   output rsp_word_type rsp_data,
   input  logic         rsp_stall
);

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type out_ff, out_in;
   rsp_word_type skid_ff, skid_in;
   logic         pop;

   assign pop = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (pop || !out_valid_ff) begin
         // The skid word is older than anything arriving now, so it goes first.
         out_in        = skid_valid_ff ? skid_ff : push_word;
         out_valid_in  = skid_valid_ff || push;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_in       = push_word;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held without an output word");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("result pushed into a full queue");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      pop && skid_valid_ff |=> out_valid_ff && !skid_valid_ff)
      else $error("skid word lost on drain");

endmodule

@@ rtl/der_tag_length_header_parser.sv @@
// Top level of the DER tag/length header parser: byte state machine and result queue.
// One byte is accepted per cycle while req_stall is low.
// A result is registered into the output register, or into the skid register under an output stall,
// when the byte or end marker that closes it is accepted; the state is updated for every accepted word.
// Input stalls only when both result slots are full under an output stall.
// Synchronous active-high reset returns the parser to idle and empties the result queue.
module der_tag_length_header_parser
   import dtlh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data
);

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_TAG  = 2'd1,
      PH_LEN0 = 2'd2,
      PH_LENX = 2'd3
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [7:0]              ident_ff, ident_in;
   logic [27:0]             num_ff, num_in;
   logic [TAG_GROUPS_W-1:0] groups_ff, groups_in;
   logic [31:0]             len_ff, len_in;
   logic [LEN_LEFT_W-1:0]   left_ff, left_in;
   logic [3:0]              count_ff, count_in;

   logic                    queue_full;
   logic                    req_take;
   logic                    push;
   status_type              status;
   logic [31:0]             rsp_len;
   logic [31:0]             len_shift;
   logic [7:0]              b;
   rsp_word_type            push_word;

   assign req_stall = queue_full;
   assign req_take  = req_valid && !req_stall;
   assign b         = req_data.data_byte;
   assign len_shift = {len_ff[23:0], b};

   always_comb begin
      phase_in  = phase_ff;
      ident_in  = ident_ff;
      num_in    = num_ff;
      groups_in = groups_ff;
      len_in    = len_ff;
      left_in   = left_ff;
      count_in  = count_ff;
      push      = 1'b0;
      status    = ST_OK;
      rsp_len   = '0;
      if (req_take) begin
         if (req_data.kind) begin
            push   = 1'b1;
            status = ST_TRUNC;
         end else begin
            if (phase_ff != PH_IDLE && count_ff != 4'hf) begin
               count_in = count_ff + 4'd1;
            end
            unique case (phase_ff)
               PH_IDLE: begin
                  count_in  = 4'd1;
                  ident_in  = b;
                  groups_in = '0;
                  len_in    = '0;
                  left_in   = '0;
                  if ((b & TAG_LOW_MASK) == TAG_LOW_MASK) begin
                     num_in   = '0;
                     phase_in = PH_TAG;
                  end else begin
                     num_in   = {23'd0, b[4:0]};
                     phase_in = PH_LEN0;
                  end
               end
               PH_TAG: begin
                  if (groups_ff >= TAG_GROUPS_W'(MAX_TAG_GROUPS) || num_ff[27:21] != 7'd0) begin
                     push   = 1'b1;
                     status = ST_TAGBIG;
                  end else begin
                     num_in    = {num_ff[20:0], b[6:0]};
                     groups_in = groups_ff + TAG_GROUPS_W'(1);
                     if ((b & LONG_FORM_BIT) == 8'd0) begin
                        phase_in = PH_LEN0;
                     end
                  end
               end
               PH_LEN0: begin
                  if (b == 8'd0 && ident_ff == 8'd0) begin
                     push   = 1'b1;
                     status = ST_EOC;
                  end else if (b == LONG_FORM_BIT) begin
                     push   = 1'b1;
                     status = ST_INDEF;
                  end else if ((b & LONG_FORM_BIT) == 8'd0) begin
                     push    = 1'b1;
                     status  = ST_OK;
                     rsp_len = {24'd0, b};
                  end else if (b[6:0] > 7'(MAX_LENGTH_BYTES)) begin
                     push   = 1'b1;
                     status = ST_LENBIG;
                  end else begin
                     left_in  = b[LEN_LEFT_W-1:0];
                     len_in   = '0;
                     phase_in = PH_LENX;
                  end
               end
               PH_LENX: begin
                  if (len_ff[31:24] != 8'd0) begin
                     push   = 1'b1;
                     status = ST_LENBIG;
                  end else begin
                     len_in = len_shift;
                     if (left_ff != '0) begin
                        left_in = left_ff - LEN_LEFT_W'(1);
                     end
                     if (left_ff <= LEN_LEFT_W'(1)) begin
                        push    = 1'b1;
                        status  = ST_OK;
                        rsp_len = len_shift;
                     end
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
         // Every result closes the header and leaves the parser clean for the next one.
         if (push) begin
            phase_in  = PH_IDLE;
            ident_in  = '0;
            num_in    = '0;
            groups_in = '0;
            len_in    = '0;
            left_in   = '0;
         end
      end
   end

   assign push_word.status         = status;
   assign push_word.tag_class      = ident_ff[7:6] & CLASS_MASK[7:6];
   assign push_word.tag_number     = num_ff;
   assign push_word.content_length = rsp_len;
   assign push_word.header_bytes   = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         ident_ff  <= '0;
         num_ff    <= '0;
         groups_ff <= '0;
         len_ff    <= '0;
         left_ff   <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         ident_ff  <= ident_in;
         num_ff    <= num_in;
         groups_ff <= groups_in;
         len_ff    <= len_in;
         left_ff   <= left_in;
         count_ff  <= push ? 4'd0 : count_in;
      end
   end

   dtlh_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   a_result_ends_header: assert property (@(posedge clock) disable iff (reset)
      push |=> phase_ff == PH_IDLE && count_ff == 4'd0)
      else $error("parser did not return to idle after a result");

   a_count_in_header: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> count_ff != 4'd0)
      else $error("header byte count is zero inside a header");

   a_length_bytes_pending: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_LENX |-> left_ff != '0 && left_ff <= LEN_LEFT_W'(MAX_LENGTH_BYTES))
      else $error("long-form length count out of range");

endmodule

@@ verif/der_tag_length_header_parser_tb.sv @@
// Self-checking testbench of the DER tag/length header parser, with a byte-level parser mirror.
`timescale 1ns / 100ps

module der_tag_length_header_parser_tb
   import dtlh_pkg::*;
();

   typedef enum logic [1:0] {
      HDR_IDLE,
      HDR_TAG,
      HDR_LEN_FIRST,
      HDR_LEN_MORE
   } hdr_phase_type;

   class header_scoreboard;
      hdr_phase_type phase;
      logic [7:0]    ident;
      logic [27:0]   tag_acc;
      int unsigned   groups;
      logic [31:0]   len_acc;
      int unsigned   len_left;
      logic [3:0]    hdr_count;
      rsp_word_type  expected_headers[$];
      int            mismatch_count;

      function new();
         clear();
         mismatch_count = 0;
      endfunction

      function void clear();
         phase     = HDR_IDLE;
         ident     = '0;
         tag_acc   = '0;
         groups    = 0;
         len_acc   = '0;
         len_left  = 0;
         hdr_count = '0;
      endfunction

      function void push_header(status_type st, logic [31:0] len);
         rsp_word_type w;
         w.status         = st;
         w.tag_class      = ident[7:6];
         w.tag_number     = tag_acc;
         w.content_length = len;
         w.header_bytes   = hdr_count;
         expected_headers.push_back(w);
         clear();
      endfunction

      // Mirrors the parser for one accepted word and queues any header it closes.
      function void note_byte(req_word_type w);
         logic [7:0] b;
         b = w.data_byte;
         if (w.kind) begin
            push_header(ST_TRUNC, '0);
            return;
         end
         if (phase != HDR_IDLE && hdr_count != 4'hf)
            hdr_count++;
         case (phase)
            HDR_IDLE: begin
               clear();
               hdr_count = 4'd1;
               ident     = b;
               if ((b & TAG_LOW_MASK) == TAG_LOW_MASK) begin
                  phase = HDR_TAG;
               end else begin
                  tag_acc = {23'b0, b[4:0]};
                  phase   = HDR_LEN_FIRST;
               end
            end
            HDR_TAG: begin
               if (groups >= MAX_TAG_GROUPS || tag_acc[27:21] != '0) begin
                  push_header(ST_TAGBIG, '0);
               end else begin
                  tag_acc = {tag_acc[20:0], b[6:0]};
                  groups++;
                  if (!b[7])
                     phase = HDR_LEN_FIRST;
               end
            end
            HDR_LEN_FIRST: begin
               if (b == 8'h00 && ident == 8'h00)
                  push_header(ST_EOC, '0);
               else if (b == LONG_FORM_BIT)
                  push_header(ST_INDEF, '0);
               else if (!b[7])
                  push_header(ST_OK, {24'b0, b});
               else if (b[6:0] > MAX_LENGTH_BYTES)
                  push_header(ST_LENBIG, '0);
               else begin
                  len_left = 32'(b[6:0]);
                  len_acc  = '0;
                  phase    = HDR_LEN_MORE;
               end
            end
            HDR_LEN_MORE: begin
               if (len_acc[31:24] != '0) begin
                  push_header(ST_LENBIG, '0);
               end else begin
                  len_acc = {len_acc[23:0], b};
                  if (len_left > 0)
                     len_left--;
                  if (len_left == 0)
                     push_header(ST_OK, len_acc);
               end
            end
            default: clear();
         endcase
      endfunction

      function void compare_field(string field_name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field_name, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_header(rsp_word_type got);
         rsp_word_type want;
         if (expected_headers.size() == 0) begin
            $display("%0t: unexpected header word, expected none, actual %h", $time, got);
            mismatch_count++;
            return;
         end
         want = expected_headers.pop_front();
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("tag_class", 32'(want.tag_class), 32'(got.tag_class));
         compare_field("tag_number", 32'(want.tag_number), 32'(got.tag_number));
         compare_field("content_length", want.content_length, got.content_length);
         compare_field("header_bytes", 32'(want.header_bytes), 32'(got.header_bytes));
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_data;

   header_scoreboard scoreboard;
   int               burst_left;
   int               items_sent;
   logic             hold_off;

   der_tag_length_header_parser u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         scoreboard.check_header(rsp_data);
   end

   // Receiver stall pattern; every seventh segment it holds off long enough to back up the parser.
   initial begin : rsp_pattern
      int seg_idx;
      int seg_len;
      int mode;
      int tick;
      rsp_stall = 1'b0;
      hold_off  = 1'b0;
      seg_idx   = 0;
      tick      = 0;
      forever begin
         seg_idx++;
         if (seg_idx % 7 == 3) begin
            mode    = 4;
            seg_len = 150;
         end else begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(10, 120);
         end
         hold_off = (mode == 4);
         repeat (seg_len) begin
            @(negedge clock);
            tick++;
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= 1'($urandom_range(0, 1));
               2:       rsp_stall <= (tick % 3 == 0);
               3:       rsp_stall <= ($urandom_range(0, 9) < 8);
               default: rsp_stall <= 1'b1;
            endcase
         end
      end
   end

   task automatic send_word(input logic kind, input logic [7:0] b);
      req_word_type w;
      int           gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = 0;
         if (!hold_off && $urandom_range(0, 9) >= 3)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      w.kind      = kind;
      w.data_byte = b;
      req_data  <= w;
      req_valid <= 1'b1;
      do
         @(posedge clock);
      while (req_stall);
      scoreboard.note_byte(w);
      items_sent++;
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      int sel;
      sel = $urandom_range(0, 5);
      if (sel == 0)
         return 8'h00;
      else if (sel == 1)
         return 8'hff;
      return 8'($urandom_range(0, 255));
   endfunction

   // Mostly well-formed headers with random content, some noise, some cut short by an end marker.
   task automatic send_random_header();
      logic [7:0] seq[$];
      logic [7:0] id;
      logic [6:0] grp;
      int         choice;
      int         n;
      int         nl;
      int         lc;
      int         cut;
      int         i;
      bit         overflow;
      choice   = $urandom_range(0, 99);
      overflow = 1'b0;
      if (choice < 8) begin
         n = $urandom_range(1, 6);
         repeat (n) seq.push_back(8'($urandom_range(0, 255)));
      end else if (choice < 11) begin
         seq.push_back(8'h00);
         seq.push_back(8'h00);
      end else begin
         id = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 2) == 0)
            id[4:0] = 5'h1f;
         else if (id[4:0] == 5'h1f)
            id[4:0] = 5'($urandom_range(0, 30));
         seq.push_back(id);
         if (id[4:0] == 5'h1f) begin
            n = ($urandom_range(0, 9) == 0) ? MAX_TAG_GROUPS + 1 : $urandom_range(1, MAX_TAG_GROUPS);
            overflow = (n > MAX_TAG_GROUPS);
            for (i = 0; i < n; i++) begin
               grp = ($urandom_range(0, 7) == 0) ? 7'h00 : 7'($urandom_range(0, 127));
               seq.push_back({(i < n - 1), grp});
            end
         end
         if (!overflow) begin
            lc = $urandom_range(0, 99);
            if (lc < 40) begin
               seq.push_back(8'($urandom_range(0, 127)));
            end else if (lc < 80) begin
               nl = $urandom_range(1, MAX_LENGTH_BYTES);
               seq.push_back(LONG_FORM_BIT | 8'(nl));
               repeat (nl) seq.push_back(pick_byte());
            end else if (lc < 88) begin
               seq.push_back(LONG_FORM_BIT);
            end else begin
               seq.push_back(8'($urandom_range(MAX_LENGTH_BYTES + 129, 255)));
            end
         end
      end
      cut = seq.size();
      if ($urandom_range(0, 19) == 0)
         cut = $urandom_range(0, seq.size() - 1);
      for (i = 0; i < cut; i++)
         send_word(1'b0, seq[i]);
      if (cut < seq.size())
         send_word(1'b1, 8'($urandom_range(0, 255)));
   endtask

   initial begin : stimulus
      logic [7:0] directed[$];
      scoreboard = new();
      burst_left = 0;
      items_sent = 0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // End marker with no header open, then end-of-contents, the largest long-form length,
      // a length of length beyond the limit, the largest high tag with indefinite length,
      // a tag with too many groups, and a header cut short after its identifier.
      send_word(1'b1, 8'hff);
      directed = '{8'h00, 8'h00,
                   8'h02, 8'h84, 8'hff, 8'hff, 8'hff, 8'hff,
                   8'h04, 8'h85,
                   8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h80,
                   8'h9f, 8'h80, 8'h80, 8'h80, 8'h80, 8'h01,
                   8'h41};
      foreach (directed[i])
         send_word(1'b0, directed[i]);
      send_word(1'b1, 8'h00);

      while (items_sent < 1925)
         send_random_header();

      req_valid <= 1'b0;
      while (scoreboard.expected_headers.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (scoreboard.mismatch_count == 0 && scoreboard.expected_headers.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/dtlh_pkg.sv
rtl/dtlh_rsp_queue.sv
rtl/der_tag_length_header_parser.sv
verif/der_tag_length_header_parser_tb.sv
